[hdl/plane_tilt_point_warp_macros.svh]
// ----------------------------------------------------------------------------
// Plane tilt point warp assertion macros
// Implication checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PLANE_TILT_POINT_WARP_MACROS_SVH
`define PLANE_TILT_POINT_WARP_MACROS_SVH

// same-cycle implication
`define PTPW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTPW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ptpw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpw_pkg
// Types, constants and arithmetic helpers of the plane tilt point warp.
// ----------------------------------------------------------------------------
package ptpw_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int SLOTS         = TABLE_ENTRIES + 1;
  localparam int SLOT_W        = $clog2(SLOTS);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [SLOT_W-1:0] DEF_SLOT = SLOT_W'(TABLE_ENTRIES);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(TABLE_ENTRIES);

  typedef logic signed [47:0] val_t;
  typedef logic signed [63:0] prod_t;
  typedef logic signed [17:0] coef_t;

  // 0.07, 0.14 and 0.06 as Q0.16
  localparam coef_t K_BEND_H  = 18'sd4588;
  localparam coef_t K_SHIFT_H = 18'sd9175;
  localparam coef_t K_V       = 18'sd3932;

  localparam prod_t MAX32 = 64'sd2147483647;
  localparam prod_t MIN32 = -64'sd2147483648;

  typedef enum logic [1:0] {
    OP_REG  = 2'd0,
    OP_DEF  = 2'd1,
    OP_WARP = 2'd2,
    OP_CLR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [31:0] width;
    logic signed [31:0] height;
    logic signed [31:0] org_x;
    logic signed [31:0] org_y;
    logic [1:0]         flips;
    logic signed [15:0] cos_v;
    logic signed [15:0] sin_v;
    logic [15:0]        scale;
  } desc_t;

  // round half up, then shift right by s
  function automatic prod_t rnd(input prod_t v, input int unsigned s);
    prod_t half;
    half = prod_t'(64'sd1 <<< (s - 1));
    return (v + half) >>> s;
  endfunction

  function automatic prod_t mul(input val_t a, input coef_t b);
    logic signed [65:0] full;
    full = a * b;
    return full[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(input prod_t v);
    logic signed [31:0] r;
    if (v > MAX32) begin
      r = 32'sh7fffffff;
    end else if (v < MIN32) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[hdl/plane_tilt_point_warp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plane_tilt_point_warp
// Keyed plane descriptor table with default entry and tilt warp of points.
// ----------------------------------------------------------------------------
// One request at a time. Set default and clear all go from dispatch to the
// result register; register searches the stored entries in order (the key
// memory is read one entry per S_SRCH/S_CMP pass); a warp without tilt goes
// from dispatch to the result, a warp that hits the one-entry cache skips the
// search, and a warp that misses it searches the stored entries, falling back
// to the default slot. The warp math runs as a sequence of registered multiply
// steps on a descriptor read from the one-read, one-write descriptor memory.
`include "plane_tilt_point_warp_macros.svh"

module plane_tilt_point_warp
  import ptpw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic [15:0]        in_key,
  input  logic signed [31:0] in_coord_x_or_width,
  input  logic signed [31:0] in_coord_y_or_height,
  input  logic signed [31:0] in_offset_x,
  input  logic signed [31:0] in_offset_y,
  input  logic [1:0]         in_flips,
  input  logic signed [15:0] in_rot_cos,
  input  logic signed [15:0] in_rot_sin,
  input  logic [15:0]        in_plane_scale,
  input  logic signed [15:0] in_tilt_h,
  input  logic signed [15:0] in_tilt_v,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic [1:0]         out_status
);

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_DISP = 15'b000000000000010,
    S_SRCH = 15'b000000000000100,
    S_CMP  = 15'b000000000001000,
    S_RD   = 15'b000000000010000,
    S_LD   = 15'b000000000100000,
    S_SUB  = 15'b000000001000000,
    S_ROT1 = 15'b000000010000000,
    S_ROT2 = 15'b000000100000000,
    S_T1   = 15'b000001000000000,
    S_T2   = 15'b000010000000000,
    S_T3   = 15'b000100000000000,
    S_T4   = 15'b001000000000000,
    S_R2   = 15'b010000000000000,
    S_OUT  = 15'b100000000000000
  } state_t;

  state_t             state_r;
  op_t                op_r;
  logic [15:0]        key_r;
  desc_t              rdesc_r;
  logic signed [15:0] th_r, tv_r;

  logic [CNT_W-1:0]   cnt_r, idx_r;
  logic               cache_valid_r;
  logic [15:0]        cache_key_r;
  logic [SLOT_W-1:0]  cache_slot_r, slot_r;
  logic               def_valid_r;
  logic               rot_r;
  logic               back_r;
  desc_t              d_r;
  val_t               x_r, y_r, bx_r, by_r;
  prod_t              p0_r, p1_r, p2_r, p3_r;
  logic signed [31:0] res_x_r, res_y_r;
  status_t            res_st_r;

  logic               out_valid_r;
  logic signed [31:0] out_x_r, out_y_r;
  logic [1:0]         out_st_r;

  logic [15:0]        key_mem [0:TABLE_ENTRIES-1];
  desc_t              desc_mem [0:SLOTS-1];
  logic [15:0]        key_rd_r;
  desc_t              desc_rd_r;

  logic               key_we, desc_we;
  logic [SLOT_W-1:0]  desc_waddr;
  logic               in_range;
  val_t               rot_x, rot_y, abs_x, abs_y, tilt_x, tilt_y;
  prod_t              bk_x, bk_y;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_x      = out_x_r;
  assign out_y      = out_y_r;
  assign out_status = out_st_r;

  assign in_range   = (idx_r < cnt_r);
  assign key_we     = (state_r == S_SRCH) && !in_range && (op_r == OP_REG) &&
                      (cnt_r < CNT_FULL);
  assign desc_we    = key_we || ((state_r == S_DISP) && (op_r == OP_DEF));
  assign desc_waddr = (op_r == OP_DEF) ? DEF_SLOT : SLOT_W'(cnt_r);

  always_ff @(posedge clk) begin
    key_rd_r  <= key_mem[idx_r[IDX_W-1:0]];
    desc_rd_r <= desc_mem[slot_r];
    if (key_we) begin
      key_mem[cnt_r[IDX_W-1:0]] <= key_r;
    end
    if (desc_we) begin
      desc_mem[desc_waddr] <= rdesc_r;
    end
  end

  always_comb begin
    if (rot_r) begin
      rot_x = val_t'(rnd(p0_r + p1_r, 14));
      rot_y = val_t'(rnd(p2_r - p3_r, 14));
    end else begin
      rot_x = x_r;
      rot_y = y_r;
    end
    abs_x  = x_r[47] ? -x_r : x_r;
    abs_y  = y_r[47] ? -y_r : y_r;
    tilt_x = (th_r != 16'sd0) ? x_r - bx_r - val_t'(rnd(p1_r, 16)) : x_r;
    tilt_y = (tv_r != 16'sd0) ? y_r - by_r - val_t'(rnd(p3_r, 16)) : y_r;
    if (rot_r) begin
      bk_x = rnd(p0_r - p1_r, 14);
      bk_y = rnd(p3_r + p2_r, 14);
    end else begin
      bk_x = prod_t'(x_r);
      bk_y = prod_t'(y_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      idx_r         <= '0;
      cache_valid_r <= 1'b0;
      cache_key_r   <= '0;
      cache_slot_r  <= '0;
      slot_r        <= '0;
      def_valid_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r          <= op_t'(in_operation);
            key_r         <= in_key;
            rdesc_r.width <= in_coord_x_or_width;
            rdesc_r.height <= in_coord_y_or_height;
            rdesc_r.org_x <= in_offset_x;
            rdesc_r.org_y <= in_offset_y;
            rdesc_r.flips <= in_flips;
            rdesc_r.cos_v <= in_rot_cos;
            rdesc_r.sin_v <= in_rot_sin;
            rdesc_r.scale <= in_plane_scale;
            th_r          <= in_tilt_h;
            tv_r          <= in_tilt_v;
            state_r       <= S_DISP;
          end
        end
        S_DISP: begin
          res_x_r  <= (op_r == OP_WARP) ? rdesc_r.width : '0;
          res_y_r  <= (op_r == OP_WARP) ? rdesc_r.height : '0;
          res_st_r <= ST_DONE;
          idx_r    <= '0;
          unique case (op_r)
            OP_REG: state_r <= S_SRCH;
            OP_DEF: begin
              def_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end
            OP_CLR: begin
              cnt_r         <= '0;
              cache_valid_r <= 1'b0;
              cache_key_r   <= '0;
              cache_slot_r  <= '0;
              def_valid_r   <= 1'b0;
              state_r       <= S_OUT;
            end
            OP_WARP: begin
              if (th_r == 16'sd0 && tv_r == 16'sd0) begin
                state_r <= S_OUT;
              end else if (cache_valid_r && cache_key_r == key_r) begin
                slot_r  <= cache_slot_r;
                state_r <= S_RD;
              end else begin
                state_r <= S_SRCH;
              end
            end
            default: state_r <= S_OUT;
          endcase
        end
        S_SRCH: begin
          if (in_range) begin
            state_r <= S_CMP;
          end else if (op_r == OP_REG) begin
            if (cnt_r < CNT_FULL) begin
              cnt_r <= cnt_r + 1'b1;
            end else begin
              res_st_r <= ST_FULL;
            end
            state_r <= S_OUT;
          end else begin
            slot_r        <= DEF_SLOT;
            cache_valid_r <= 1'b1;
            cache_key_r   <= key_r;
            cache_slot_r  <= DEF_SLOT;
            state_r       <= S_RD;
          end
        end
        S_CMP: begin
          if (key_rd_r == key_r) begin
            cache_valid_r <= 1'b1;
            cache_key_r   <= key_r;
            cache_slot_r  <= SLOT_W'(idx_r);
            slot_r        <= SLOT_W'(idx_r);
            if (op_r == OP_REG) begin
              res_st_r <= ST_DUP;
              state_r  <= S_OUT;
            end else begin
              state_r <= S_RD;
            end
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_SRCH;
          end
        end
        S_RD: state_r <= S_LD;
        S_LD: begin
          if (slot_r == DEF_SLOT && !def_valid_r) begin
            d_r   <= '0;
            rot_r <= 1'b0;
          end else begin
            d_r   <= desc_rd_r;
            rot_r <= !(desc_rd_r.cos_v == 16'sd0 && desc_rd_r.sin_v == 16'sd0);
          end
          back_r  <= 1'b0;
          state_r <= S_SUB;
        end
        S_SUB: begin
          x_r     <= val_t'(rdesc_r.width) - val_t'(d_r.org_x);
          y_r     <= val_t'(rdesc_r.height) - val_t'(d_r.org_y);
          state_r <= S_ROT1;
        end
        S_ROT1: begin
          p0_r    <= mul(x_r, coef_t'(d_r.cos_v));
          p1_r    <= mul(y_r, coef_t'(d_r.sin_v));
          p2_r    <= mul(y_r, coef_t'(d_r.cos_v));
          p3_r    <= mul(x_r, coef_t'(d_r.sin_v));
          state_r <= back_r ? S_R2 : S_ROT2;
        end
        S_ROT2: begin
          x_r     <= d_r.flips[0] ? -rot_x : rot_x;
          y_r     <= d_r.flips[1] ? -rot_y : rot_y;
          state_r <= S_T1;
        end
        S_T1: begin
          p0_r    <= mul(abs_x, coef_t'(th_r));
          p1_r    <= mul(val_t'(d_r.width), coef_t'({2'b00, d_r.scale}));
          p2_r    <= mul(abs_y, coef_t'(tv_r));
          p3_r    <= mul(val_t'(d_r.height), coef_t'({2'b00, d_r.scale}));
          state_r <= S_T2;
        end
        S_T2: begin
          p0_r    <= mul(val_t'(rnd(p0_r, 14)), K_BEND_H);
          p1_r    <= mul(val_t'(rnd(p1_r, 9)), coef_t'(th_r));
          p2_r    <= mul(val_t'(rnd(p2_r, 14)), K_V);
          p3_r    <= mul(val_t'(rnd(p3_r, 9)), coef_t'(tv_r));
          state_r <= S_T3;
        end
        S_T3: begin
          bx_r    <= val_t'(rnd(p0_r, 16));
          p1_r    <= mul(val_t'(rnd(p1_r, 14)), K_SHIFT_H);
          by_r    <= val_t'(rnd(p2_r, 16));
          p3_r    <= mul(val_t'(rnd(p3_r, 14)), K_V);
          state_r <= S_T4;
        end
        S_T4: begin
          x_r     <= d_r.flips[0] ? -tilt_x : tilt_x;
          y_r     <= d_r.flips[1] ? -tilt_y : tilt_y;
          back_r  <= 1'b1;
          state_r <= S_ROT1;
        end
        S_R2: begin
          res_x_r <= sat32(bk_x + prod_t'(d_r.org_x));
          res_y_r <= sat32(bk_y + prod_t'(d_r.org_y));
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_x_r     <= res_x_r;
            out_y_r     <= res_y_r;
            out_st_r    <= res_st_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `PTPW_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_FULL, "entry count above table size")
  `PTPW_ASSERT_NOW(a_cache_slot, cache_valid_r,
    cache_slot_r == DEF_SLOT || SLOT_W'(cnt_r) > cache_slot_r, "cache points past table")
  `PTPW_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state_r == S_DISP,
    "accepted request not dispatched")
  `PTPW_ASSERT_NOW(a_write_slot, key_we, cnt_r < CNT_FULL, "table write when full")

endmodule
